>>> sv/bbus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbus_pkg
// shared types and constants of the 3x3 box-blur unsharp sharpener
// ----------------------------------------------------------------------------
package bbus_pkg;

  // line store depth and derived widths
  localparam int MAX_WIDTH    = 1024;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int HEIGHT_LIMIT = 4096;

  // configuration registers
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [WIDTH_W-1:0]   RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0]  RESET_HEIGHT = 13'd480;

  // compare widths: column + 1 and row + 2 must not wrap
  localparam int CMP_W  = (WIDTH_W > ADDR_W + 1) ? WIDTH_W : ADDR_W + 1;
  localparam int HCMP_W = HEIGHT_W + 1;
  localparam int ROW_W  = 13;

  // request codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAD   = 1'b1;

  // box filter arithmetic
  localparam int CHAN_W      = 8;
  localparam int WIN_TAPS    = 9;
  localparam int SUM_W       = CHAN_W + $clog2(WIN_TAPS);
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_9     = (2**RECIP_SHIFT + WIN_TAPS - 1) / WIN_TAPS;
  localparam int RECIP_W     = $clog2(RECIP_9 + 1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_t;

  typedef struct packed {
    logic              operation;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_last;
  } out_req_t;

  typedef struct packed {
    logic first;
    logic emit_prev;
    logic emit_cur;
    logic last;
    logic frame_end;
    logic has_up;
    logic has_mid;
  } stage_ctrl_t;

endpackage

>>> sv/bbus_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbus_in_if
// pixel request channel into the sharpener
// ----------------------------------------------------------------------------
interface bbus_in_if;
  logic              valid;
  logic              ready;
  bbus_pkg::in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/bbus_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbus_out_if
// sharpened pixel request channel out of the sharpener
// ----------------------------------------------------------------------------
interface bbus_out_if;
  logic               valid;
  logic               ready;
  bbus_pkg::out_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/box_blur_unsharp_sharpen_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_unsharp_sharpen_top
// 3x3 box-blur unsharp sharpener for a raster stream of RGB pixels
// ----------------------------------------------------------------------------
// Takes one pixel request per clock in raster order, unless pixel_out
// stalls, and returns at most one sharpened pixel per request. Each channel
// is blurred with a 3x3 box (zero padding, sum / 9 truncated), and the
// result is orig + (orig - blur), both mod 256. The result for a pixel comes
// out with the request that arrives frame_width + 1 positions after it, so
// a frame is frame_width * frame_height pixels followed by frame_width + 1
// pad requests; the last result carries frame_last. The input register
// loads when a request is accepted; results go through the window snapshot,
// channel sums and output register to pixel_out. The rate is set by the
// line memory: one read and one write per cycle at the current column, with
// a bypass when back-to-back requests hit the same column (frame_width of
// one). Writes fill the memory from column zero upward after reset, so a
// fill count marks the entries that hold data and the others read as zero;
// no clearing pass is needed. frame_width and frame_height are to be written
// only while the block is idle; the block does not enforce this. Zero is
// taken as one, and values above 1024 / 4096 are clamped.
// ----------------------------------------------------------------------------
module box_blur_unsharp_sharpen_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bbus_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbus_pkg::CFG_DATA_W-1:0]  cfg_data,
  bbus_in_if.sink                          pixel_in,
  bbus_out_if.source                       pixel_out
);

  // configuration registers
  logic [bbus_pkg::WIDTH_W-1:0]  frame_width;
  logic [bbus_pkg::HEIGHT_W-1:0] frame_height;

  // raster position of the next request
  logic [bbus_pkg::ADDR_W-1:0] col_count;
  logic [bbus_pkg::ROW_W-1:0]  row_count;

  // clamped geometry
  logic [bbus_pkg::CMP_W-1:0]  width_eff;
  logic [bbus_pkg::HCMP_W-1:0] height_eff;
  logic [bbus_pkg::HCMP_W-1:0] row_ext;
  logic [bbus_pkg::CMP_W-1:0]  col_inc;
  logic                        row_done;

  // front decode of the incoming request
  bbus_pkg::stage_ctrl_t in_ctrl;
  bbus_pkg::pixel_t      in_pix;
  logic                  accept;

  // stage 1: input register, window update, line memory access
  logic                        s1_valid;
  bbus_pkg::stage_ctrl_t       s1_ctrl;
  bbus_pkg::pixel_t            s1_pix;
  logic [bbus_pkg::ADDR_W-1:0] s1_col;
  logic                        s1_emit;
  logic                        s1_fire;
  logic                        s1_ready;
  logic                        s1_write;

  // line memory: {row two above, row just above} per column
  bbus_pkg::line_t line_mem [bbus_pkg::MAX_WIDTH];
  bbus_pkg::line_t line_q;
  bbus_pkg::line_t fwd_data;
  logic            fwd_hit;
  bbus_pkg::line_t line_raw;
  bbus_pkg::pixel_t up_pix;
  bbus_pkg::pixel_t mid_pix;
  // entries below line_fill have been written since reset
  logic [bbus_pkg::ADDR_W:0] line_fill;
  logic                      line_ok;

  // 3x3 window: rows upper, middle, incoming; columns oldest to newest
  bbus_pkg::pixel_t win       [bbus_pkg::WIN_TAPS];
  bbus_pkg::pixel_t win_shz   [bbus_pkg::WIN_TAPS];
  bbus_pkg::pixel_t win_new   [bbus_pkg::WIN_TAPS];
  bbus_pkg::pixel_t win_next  [bbus_pkg::WIN_TAPS];
  bbus_pkg::pixel_t emit_win  [bbus_pkg::WIN_TAPS];
  bbus_pkg::pixel_t new_col   [3];

  // stage 2: snapshot of the window to be reported
  logic             s2_valid;
  logic             s2_ready;
  bbus_pkg::pixel_t s2_win [bbus_pkg::WIN_TAPS];
  logic             s2_last;

  // stage 3: channel sums
  logic                       s3_valid;
  logic                       s3_ready;
  logic [bbus_pkg::SUM_W-1:0] sum_red;
  logic [bbus_pkg::SUM_W-1:0] sum_green;
  logic [bbus_pkg::SUM_W-1:0] sum_blue;
  logic [bbus_pkg::SUM_W-1:0] s3_sum_red;
  logic [bbus_pkg::SUM_W-1:0] s3_sum_green;
  logic [bbus_pkg::SUM_W-1:0] s3_sum_blue;
  bbus_pkg::pixel_t           s3_orig;
  logic                       s3_last;

  // output register
  logic               out_valid;
  logic               out_ready;
  bbus_pkg::out_req_t out_data;

  // blur by multiply with the reciprocal of nine, then sharpen, all mod 256
  function automatic logic [bbus_pkg::CHAN_W-1:0] sharpen (
    input logic [bbus_pkg::SUM_W-1:0]  sum,
    input logic [bbus_pkg::CHAN_W-1:0] orig
  );
    logic [bbus_pkg::SUM_W+bbus_pkg::RECIP_W-1:0] prod;
    logic [bbus_pkg::CHAN_W-1:0]                  smooth;
    logic [bbus_pkg::CHAN_W-1:0]                  detail;
    prod   = (bbus_pkg::SUM_W + bbus_pkg::RECIP_W)'(sum)
           * (bbus_pkg::SUM_W + bbus_pkg::RECIP_W)'(bbus_pkg::RECIP_9);
    smooth = prod[bbus_pkg::RECIP_SHIFT +: bbus_pkg::CHAN_W];
    detail = orig - smooth;
    return orig + detail;
  endfunction

  // --------------------------------------------------------------------------
  // configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbus_pkg::RESET_WIDTH;
      frame_height <= bbus_pkg::RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bbus_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[bbus_pkg::WIDTH_W-1:0];
        bbus_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[bbus_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp width to 1..MAX_WIDTH and height to 1..HEIGHT_LIMIT
  always_comb begin
    if (frame_width == '0) begin
      width_eff = bbus_pkg::CMP_W'(1);
    end else if (bbus_pkg::CMP_W'(frame_width) > bbus_pkg::CMP_W'(bbus_pkg::MAX_WIDTH)) begin
      width_eff = bbus_pkg::CMP_W'(bbus_pkg::MAX_WIDTH);
    end else begin
      width_eff = bbus_pkg::CMP_W'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = bbus_pkg::HCMP_W'(1);
    end else if (bbus_pkg::HCMP_W'(frame_height)
                 > bbus_pkg::HCMP_W'(bbus_pkg::HEIGHT_LIMIT)) begin
      height_eff = bbus_pkg::HCMP_W'(bbus_pkg::HEIGHT_LIMIT);
    end else begin
      height_eff = bbus_pkg::HCMP_W'(frame_height);
    end
  end

  // --------------------------------------------------------------------------
  // front decode: what this request does at its raster position
  // --------------------------------------------------------------------------
  always_comb begin
    row_ext  = bbus_pkg::HCMP_W'(row_count);
    col_inc  = bbus_pkg::CMP_W'(col_count) + bbus_pkg::CMP_W'(1);
    row_done = col_inc >= width_eff;

    in_ctrl.first     = (col_count == '0);
    in_ctrl.has_up    = (row_ext >= bbus_pkg::HCMP_W'(2));
    in_ctrl.has_mid   = (row_count != '0);
    // column zero closes the previous row: right-edge pixel two rows up
    in_ctrl.emit_prev = in_ctrl.first && in_ctrl.has_up
                        && (row_ext < height_eff + bbus_pkg::HCMP_W'(2));
    // two rows past the frame: report the last pixel and restart
    in_ctrl.frame_end = in_ctrl.first && (row_ext >= height_eff + bbus_pkg::HCMP_W'(1));
    in_ctrl.last      = in_ctrl.first && (row_ext == height_eff + bbus_pkg::HCMP_W'(1));
    in_ctrl.emit_cur  = !in_ctrl.first && in_ctrl.has_mid
                        && (row_ext < height_eff + bbus_pkg::HCMP_W'(1));

    // pads and anything below the frame count as a zero pixel
    if (pixel_in.data.operation == bbus_pkg::OP_PIXEL && row_ext < height_eff) begin
      in_pix.red   = pixel_in.data.red_in;
      in_pix.green = pixel_in.data.green_in;
      in_pix.blue  = pixel_in.data.blue_in;
    end else begin
      in_pix = '0;
    end
  end

  assign accept         = pixel_in.valid && s1_ready;
  assign pixel_in.ready = s1_ready;

  // raster counters advance at each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (in_ctrl.frame_end) begin
        col_count <= '0;
        row_count <= '0;
      end else if (row_done) begin
        col_count <= '0;
        row_count <= row_count + bbus_pkg::ROW_W'(1);
      end else begin
        col_count <= col_inc[bbus_pkg::ADDR_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: input register
  // --------------------------------------------------------------------------
  assign s1_emit  = s1_ctrl.emit_prev || s1_ctrl.emit_cur;
  assign s1_fire  = s1_valid && (!s1_emit || s2_ready);
  assign s1_ready = !s1_valid || s1_fire;
  assign s1_write = !s1_ctrl.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl <= in_ctrl;
      s1_pix  <= in_pix;
      s1_col  <= col_count;
    end
  end

  // line memory: read at accept, write when stage 1 retires its request
  always_ff @(posedge clk) begin
    if (s1_fire && s1_write) begin
      line_mem[s1_col] <= '{upper: line_raw.middle, middle: s1_pix};
    end
    if (accept) begin
      line_q   <= line_mem[col_count];
      line_ok  <= ({1'b0, col_count} < line_fill);
      // same column written in this cycle: take the new contents instead
      fwd_hit  <= s1_fire && s1_write && (s1_col == col_count);
      fwd_data <= '{upper: line_raw.middle, middle: s1_pix};
    end
  end

  // columns are written in order from zero, so the written entries form a prefix
  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill <= '0;
    end else if (s1_fire && s1_write && ({1'b0, s1_col} == line_fill)) begin
      line_fill <= {1'b0, s1_col} + (bbus_pkg::ADDR_W + 1)'(1);
    end
  end

  assign line_raw = fwd_hit ? fwd_data : (line_ok ? line_q : '0);
  assign up_pix   = s1_ctrl.has_up  ? line_raw.upper  : '0;
  assign mid_pix  = s1_ctrl.has_mid ? line_raw.middle : '0;

  // window update
  always_comb begin
    new_col[0] = up_pix;
    new_col[1] = mid_pix;
    new_col[2] = s1_pix;
    for (int rr = 0; rr < 3; rr++) begin
      // zero column past the right edge
      win_shz[rr*3+0] = win[rr*3+1];
      win_shz[rr*3+1] = win[rr*3+2];
      win_shz[rr*3+2] = '0;
      // row start clears columns left of the frame
      if (s1_ctrl.first) begin
        win_new[rr*3+0] = '0;
        win_new[rr*3+1] = '0;
      end else begin
        win_new[rr*3+0] = win[rr*3+1];
        win_new[rr*3+1] = win[rr*3+2];
      end
      win_new[rr*3+2] = new_col[rr];
    end
    for (int i = 0; i < bbus_pkg::WIN_TAPS; i++) begin
      win_next[i] = s1_ctrl.frame_end ? '0 : win_new[i];
      if (s1_ctrl.emit_prev) begin
        emit_win[i] = win_shz[i];
      end else begin
        emit_win[i] = win_new[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bbus_pkg::WIN_TAPS; i++) begin
        win[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < bbus_pkg::WIN_TAPS; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: window snapshot of a reported pixel
  // --------------------------------------------------------------------------
  assign s2_ready = !s2_valid || s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_fire && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_fire && s1_emit) begin
      for (int i = 0; i < bbus_pkg::WIN_TAPS; i++) begin
        s2_win[i] <= emit_win[i];
      end
      s2_last <= s1_ctrl.last;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: channel sums over the window
  // --------------------------------------------------------------------------
  always_comb begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int i = 0; i < bbus_pkg::WIN_TAPS; i++) begin
      sum_red   = sum_red   + bbus_pkg::SUM_W'(s2_win[i].red);
      sum_green = sum_green + bbus_pkg::SUM_W'(s2_win[i].green);
      sum_blue  = sum_blue  + bbus_pkg::SUM_W'(s2_win[i].blue);
    end
  end

  assign s3_ready = !s3_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_sum_red   <= sum_red;
      s3_sum_green <= sum_green;
      s3_sum_blue  <= sum_blue;
      s3_orig      <= s2_win[4];
      s3_last      <= s2_last;
    end
  end

  // --------------------------------------------------------------------------
  // output register: blur, sharpen
  // --------------------------------------------------------------------------
  assign out_ready = !out_valid || pixel_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s3_valid) begin
      out_data.red_out    <= sharpen(s3_sum_red,   s3_orig.red);
      out_data.green_out  <= sharpen(s3_sum_green, s3_orig.green);
      out_data.blue_out   <= sharpen(s3_sum_blue,  s3_orig.blue);
      out_data.frame_last <= s3_last;
    end
  end

  assign pixel_out.valid = out_valid;
  assign pixel_out.data  = out_data;

endmodule

>>> sv/bbus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbus_checker
// port-level checks of the sharpener, bound to the top level
// ----------------------------------------------------------------------------
module bbus_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bbus_pkg::out_req_t out_data
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // with the output register empty the whole pipe can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a taken result frees room back to the input in the same cycle
  a_ready_on_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind box_blur_unsharp_sharpen_top bbus_checker u_bbus_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel_in.valid),
  .in_ready  (pixel_in.ready),
  .out_valid (pixel_out.valid),
  .out_ready (pixel_out.ready),
  .out_data  (pixel_out.data)
);

>>> dv/box_blur_unsharp_sharpen_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_unsharp_sharpen_top_tb
// self-checking bench for the 3x3 box-blur unsharp sharpener
// ----------------------------------------------------------------------------
// Sends pixel and pad requests through the sharpener frame by frame. A
// behavioral line-store model predicts every sharpened pixel, and each
// result is compared with the oldest prediction. Frame sizes change between
// frames and in the middle of frames, including a widening that reaches
// line entries never written since reset. A width past the line store is
// run for a full clamped row. Both handshakes idle at random. The output
// side also holds off now and then, long enough to back up the input.
// ----------------------------------------------------------------------------
module box_blur_unsharp_sharpen_top_tb;

  localparam int     RANDOM_ITEMS  = 550;
  localparam int     SETTLE_CYCLES = 16;   // pipeline: input, snapshot, sums, output registers
  localparam int     STALL_CYCLES  = 300;
  localparam int     STALL_EVERY   = 150;  // results between output hold-offs
  localparam longint TIMEOUT_NS    = 4_000_000;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [bbus_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bbus_pkg::CFG_DATA_W-1:0] cfg_data;

  bbus_in_if  pixel_in ();
  bbus_out_if pixel_out ();

  box_blur_unsharp_sharpen_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .pixel_out (pixel_out)
  );

  // shadow of the frame registers and the sharpener state
  logic [bbus_pkg::WIDTH_W-1:0]  frame_width_reg;
  logic [bbus_pkg::HEIGHT_W-1:0] frame_height_reg;
  bbus_pkg::pixel_t              upper_row [bbus_pkg::MAX_WIDTH];
  bbus_pkg::pixel_t              middle_row [bbus_pkg::MAX_WIDTH];
  // rows upper/middle/incoming, oldest first
  bbus_pkg::pixel_t              window_px [bbus_pkg::WIN_TAPS];
  int unsigned                   next_col;
  int unsigned                   next_row;

  bbus_pkg::in_req_t  pixel_requests [$];   // requests waiting for the driver
  bbus_pkg::out_req_t expected_pixels [$];  // predicted sharpened pixels, oldest first

  int mismatch_count;
  bit steady;  // no random idling on either side while set

  // output hold-off bookkeeping, owned by the receiver process
  int results_delivered;
  int stall_left;
  int next_stall_at;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // zero reads as one, anything past the line store is clamped
  function automatic int unsigned active_width();
    int unsigned w;
    w = frame_width_reg;
    if (w == 0) w = 1;
    else if (w > bbus_pkg::MAX_WIDTH) w = bbus_pkg::MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = frame_height_reg;
    if (h == 0) h = 1;
    else if (h > bbus_pkg::HEIGHT_LIMIT) h = bbus_pkg::HEIGHT_LIMIT;
    return h;
  endfunction

  // orig + (orig - blur), everything wrapping at eight bits
  function automatic logic [bbus_pkg::CHAN_W-1:0] sharpen_chan(
      logic [bbus_pkg::CHAN_W-1:0] orig, int unsigned sum);
    logic [bbus_pkg::CHAN_W-1:0] blur;
    logic [bbus_pkg::CHAN_W-1:0] detail;
    blur   = bbus_pkg::CHAN_W'(sum / bbus_pkg::WIN_TAPS);
    detail = orig - blur;
    return orig + detail;
  endfunction

  function automatic bbus_pkg::out_req_t sharpen_centre(logic last);
    int unsigned        red_sum;
    int unsigned        green_sum;
    int unsigned        blue_sum;
    bbus_pkg::out_req_t res;
    red_sum   = 0;
    green_sum = 0;
    blue_sum  = 0;
    foreach (window_px[i]) begin
      red_sum   += window_px[i].red;
      green_sum += window_px[i].green;
      blue_sum  += window_px[i].blue;
    end
    res.red_out    = sharpen_chan(window_px[4].red, red_sum);
    res.green_out  = sharpen_chan(window_px[4].green, green_sum);
    res.blue_out   = sharpen_chan(window_px[4].blue, blue_sum);
    res.frame_last = last;
    return res;
  endfunction

  function automatic void shift_window_in(bbus_pkg::pixel_t up, bbus_pkg::pixel_t mid,
                                          bbus_pkg::pixel_t low);
    bbus_pkg::pixel_t column [3];
    column[0] = up;
    column[1] = mid;
    column[2] = low;
    for (int rr = 0; rr < 3; rr++) begin
      window_px[rr*3]   = window_px[rr*3+1];
      window_px[rr*3+1] = window_px[rr*3+2];
      window_px[rr*3+2] = column[rr];
    end
  endfunction

  function automatic void clear_window();
    foreach (window_px[i]) window_px[i] = '0;
  endfunction

  // advance the shadow state by one accepted request
  task automatic sharpen_step(bbus_pkg::in_req_t req);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int unsigned      idx;
    bbus_pkg::pixel_t pix;
    bbus_pkg::pixel_t up;
    bbus_pkg::pixel_t mid;
    w   = active_width();
    h   = active_height();
    c   = next_col;
    r   = next_row;
    pix = '0;
    // pads and anything below the last row count as black
    if (req.operation == bbus_pkg::OP_PIXEL && r < h) begin
      pix.red   = req.red_in;
      pix.green = req.green_in;
      pix.blue  = req.blue_in;
    end
    if (c == 0) begin
      // right edge of the row two up; two rows past the frame, restart
      shift_window_in('0, '0, '0);
      if (r >= 2 && r - 2 < h)
        expected_pixels.push_back(sharpen_centre(r - 2 == h - 1));
      if (r >= h + 1) begin
        next_col = 0;
        next_row = 0;
        clear_window();
        return;
      end
      clear_window();
    end
    idx = (c < bbus_pkg::MAX_WIDTH) ? c : bbus_pkg::MAX_WIDTH - 1;
    up  = (r >= 2) ? upper_row[idx] : '0;
    mid = (r >= 1) ? middle_row[idx] : '0;
    shift_window_in(up, mid, pix);
    upper_row[idx]  = middle_row[idx];
    middle_row[idx] = pix;
    if (c >= 1 && r >= 1 && r - 1 < h)
      expected_pixels.push_back(sharpen_centre(1'b0));
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1) & 32'h1FFF;
    end else begin
      next_col = c + 1;
    end
  endtask

  // requests still needed to bring the counters back to the start of a frame
  function automatic int pads_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int          n;
    w = active_width();
    h = active_height();
    c = next_col;
    r = next_row;
    if (c == 0 && r == 0) return 0;
    n = 1;
    while (!(c == 0 && r >= h + 1)) begin
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1) & 32'h1FFF;
      end else begin
        c = c + 1;
      end
      n++;
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // saturated and black channels turn up more often than chance would give
  function automatic logic [bbus_pkg::CHAN_W-1:0] random_channel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return bbus_pkg::CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bbus_pkg::in_req_t build_request(logic op,
                                                      logic [bbus_pkg::CHAN_W-1:0] red,
                                                      logic [bbus_pkg::CHAN_W-1:0] green,
                                                      logic [bbus_pkg::CHAN_W-1:0] blue);
    bbus_pkg::in_req_t req;
    req.operation = op;
    req.red_in    = red;
    req.green_in  = green;
    req.blue_in   = blue;
    return req;
  endfunction

  function automatic bbus_pkg::in_req_t random_request(logic op);
    return build_request(op, random_channel(), random_channel(), random_channel());
  endfunction

  // one frame at the current size: pixels, then the pad requests that drain
  // the last row; noise swaps request kinds and now and then cuts the frame
  // short or runs it long
  function automatic int queue_frame(int noise_pct);
    int unsigned w;
    int unsigned h;
    int          total;
    logic        op;
    w     = active_width();
    h     = active_height();
    total = int'(w * h + w + 1);
    if (noise_pct > 0 && $urandom_range(99) < 10) begin
      if ($urandom_range(1)) total -= int'($urandom_range(1, w));
      else total += int'($urandom_range(1, w));
    end
    for (int i = 0; i < total; i++) begin
      op = (i < w * h) ? bbus_pkg::OP_PIXEL : bbus_pkg::OP_PAD;
      if ($urandom_range(99) < noise_pct) op = ~op;
      pixel_requests.push_back(random_request(op));
    end
    return total;
  endfunction

  // both registers, back to back, only while the block is idle
  task automatic set_frame(int unsigned width, int unsigned height);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= bbus_pkg::REG_FRAME_WIDTH;
    cfg_data  <= bbus_pkg::CFG_DATA_W'(width);
    @(posedge clk);
    cfg_index <= bbus_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= bbus_pkg::CFG_DATA_W'(height);
    @(posedge clk);
    cfg_write <= 1'b0;
    frame_width_reg  = bbus_pkg::WIDTH_W'(width);
    frame_height_reg = bbus_pkg::HEIGHT_W'(height);
  endtask

  // all requests taken, all results in, then let the pipeline run dry
  task automatic settle();
    while (pixel_requests.size() != 0 || pixel_in.valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic finish_frame();
    int n;
    n = pads_to_frame_end();
    repeat (n) pixel_requests.push_back(random_request(bbus_pkg::OP_PAD));
    if (n > 0) settle();
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [bbus_pkg::CHAN_W-1:0] got,
                             logic [bbus_pkg::CHAN_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // request driver: one request in flight, held until taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pixel_in.valid <= 1'b0;
    end else begin
      if (pixel_in.valid && pixel_in.ready) sharpen_step(pixel_in.data);
      if (!pixel_in.valid || pixel_in.ready) begin
        if (pixel_requests.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
          pixel_in.valid <= 1'b1;
          pixel_in.data  <= pixel_requests.pop_front();
        end else begin
          pixel_in.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output side: random idling plus a long hold-off every so many results,
  // so the block fills up and pushes back on the input
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pixel_out.ready <= 1'b0;
    end else begin
      if (pixel_out.valid && pixel_out.ready) results_delivered++;
      if (stall_left > 0) begin
        stall_left--;
        pixel_out.ready <= 1'b0;
      end else if (!steady && results_delivered >= next_stall_at) begin
        stall_left    = STALL_CYCLES;
        next_stall_at = results_delivered + STALL_EVERY;
        pixel_out.ready <= 1'b0;
      end else begin
        pixel_out.ready <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bbus_pkg::out_req_t want;
    if (!rst && pixel_out.valid && pixel_out.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("sharpened pixel with none expected");
      end else begin
        want = expected_pixels.pop_front();
        check_field("red_out", pixel_out.data.red_out, want.red_out);
        check_field("green_out", pixel_out.data.green_out, want.green_out);
        check_field("blue_out", pixel_out.data.blue_out, want.blue_out);
        check_field("frame_last", bbus_pkg::CHAN_W'(pixel_out.data.frame_last),
                    bbus_pkg::CHAN_W'(want.frame_last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    int w;
    int h;
    int batch;
    int random_items;

    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = bbus_pkg::REG_FRAME_WIDTH;
    cfg_data        = '0;
    pixel_in.valid  = 1'b0;
    pixel_in.data   = '0;
    pixel_out.ready = 1'b0;
    steady            = 1'b0;
    mismatch_count    = 0;
    results_delivered = 0;
    stall_left        = 0;
    next_stall_at     = STALL_EVERY;
    frame_width_reg   = bbus_pkg::RESET_WIDTH;
    frame_height_reg  = bbus_pkg::RESET_HEIGHT;
    next_col          = 0;
    next_row          = 0;
    clear_window();
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // widen in the middle of row one: the new columns read line entries
    // that nothing has written since reset, which must read as black
    set_frame(2, 3);
    repeat (3) pixel_requests.push_back(random_request(bbus_pkg::OP_PIXEL));
    settle();
    set_frame(5, 3);
    finish_frame();

    // 3x3 frame: saturated corners, a pad inside the frame, and a pixel
    // request among the draining pads that must read as black
    set_frame(3, 3);
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'h00, 8'hff, 8'h00));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PAD, 8'hff, 8'hff, 8'hff));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'hff, 8'h00, 8'hff));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'h80, 8'h7f, 8'h01));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PAD, 8'h00, 8'h00, 8'h00));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PAD, 8'h00, 8'h00, 8'h00));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PAD, 8'hff, 8'hff, 8'hff));
    settle();

    // zero width and height both act as one: a single-pixel frame
    set_frame(0, 0);
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PAD, 8'h00, 8'h00, 8'h00));
    pixel_requests.push_back(build_request(bbus_pkg::OP_PIXEL, 8'h55, 8'haa, 8'h55));
    settle();

    // shrink the frame in the middle of row two: the column past the new
    // width closes the row, and the row past the new height ends the frame
    // without a result
    set_frame(4, 4);
    repeat (11) pixel_requests.push_back(random_request(bbus_pkg::OP_PIXEL));
    settle();
    set_frame(2, 1);
    finish_frame();

    // width past the line store: one full clamped row and the start of the
    // next, then a narrow close-out of the frame
    set_frame(2047, 2);
    repeat (bbus_pkg::MAX_WIDTH + 6)
      pixel_requests.push_back(random_request(bbus_pkg::OP_PIXEL));
    settle();
    set_frame(3, 2);
    finish_frame();

    // random frames, mostly small and well formed, a few wider; each batch
    // drains and is padded out to a frame boundary before the next resize
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      steady = (random_items >= 150 && random_items < 350);
      w = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      if ($urandom_range(19) == 0) w = 0;
      if ($urandom_range(19) == 0) h = 0;
      set_frame(w, h);
      batch = $urandom_range(1, 3);
      repeat (batch) random_items += queue_frame(3);
      settle();
      finish_frame();
    end
    steady = 1'b0;
    settle();

    if (mismatch_count == 0) begin
      $display("[box_blur_unsharp_sharpen_top] OK");
    end else begin
      $display("[box_blur_unsharp_sharpen_top] ERROR");
    end
    $finish;
  end

  // hard stop in case the handshake locks up
  initial begin
    #(TIMEOUT_NS);
    $display("[box_blur_unsharp_sharpen_top] ERROR");
    $finish;
  end

endmodule

>>> box_blur_unsharp_sharpen_top.f
sv/bbus_pkg.sv
sv/bbus_in_if.sv
sv/bbus_out_if.sv
sv/box_blur_unsharp_sharpen_top.sv
sv/bbus_checker.sv
dv/box_blur_unsharp_sharpen_top_tb.sv
